// ===== design/rbr_pkg.sv =====
// ============================================================================
// Reorder buffer retire package
// Shared sizes, operation and result codes, and entry and result types of
// the in-order reorder buffer.
// ============================================================================
package rbr_pkg;

    // Buffer geometry and retire bandwidth.
    localparam int BUFFER_DEPTH     = 32;
    localparam int MAX_RETIRE_WIDTH = 8;

    // Widths that follow from the geometry.
    localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);
    localparam int CNT_W = $clog2(MAX_RETIRE_WIDTH + 1);

    // Fixed field widths of the item and result ports.
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 5;
    localparam int ID_W     = 32;
    localparam int ADDR_W   = 32;
    localparam int RW_W     = 4;
    localparam int LIMIT_W  = 32;
    localparam int CREDIT_W = 6;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Common width for comparisons that mix pointers, counts and fields.
    localparam int CMP_W = OCC_W + CNT_W + SLOT_W + RW_W;

    // Redirect target offset past a flushing instruction.
    localparam logic [ADDR_W-1:0] REDIRECT_STEP = ADDR_W'(4);

    // Operation codes carried by an input item.
    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_RETIRE   = 2'd2,
        OP_FLUSH    = 2'd3
    } op_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_SLOT    = 2'd0,
        KIND_RETIRED = 2'd1,
        KIND_CREDIT  = 2'd2,
        KIND_FULL    = 2'd3
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RETIRE_WIDTH      = 1'b0,
        CFG_INSTRUCTION_LIMIT = 1'b1
    } cfg_index_t;

    // One buffer entry as held in the entry memory.
    typedef struct packed {
        logic              flush;
        logic              store;
        logic [ADDR_W-1:0] address;
        logic [ID_W-1:0]   id;
    } entry_t;

    // One result item.
    typedef struct packed {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot_index;
        logic [ID_W-1:0]     retired_id;
        logic                store_ack;
        logic                flush_out;
        logic [ADDR_W-1:0]   redirect_address;
        logic                halt;
        logic [CREDIT_W-1:0] credit_count;
        logic                last;
    } result_t;

    // Circular pointer increment.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(BUFFER_DEPTH - 1))
        begin
            nxt = '0;
        end
        else
        begin
            nxt = ptr + PTR_W'(1);
        end
        return nxt;
    endfunction

endpackage

// ===== design/rbr_entry_ram.sv =====
// ============================================================================
// Reorder buffer entry memory
// Synchronous single-write, single-read memory holding id, address and
// flags of every slot. Read data is registered.
// ============================================================================
module rbr_entry_ram
    import rbr_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [BUFFER_DEPTH];
    entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/rbr_ctrl.sv =====
// ============================================================================
// Reorder buffer control
// Pointers, occupancy, completion bits and the retire sequencer that walks
// the head of the entry memory one entry per cycle.
// ============================================================================
module rbr_ctrl
    import rbr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    op,
    input  logic [ID_W-1:0]    inst_id,
    input  logic [ADDR_W-1:0]  inst_address,
    input  logic               store_flag,
    input  logic               flush_flag,
    input  logic [SLOT_W-1:0]  target_slot,
    input  logic [RW_W-1:0]    retire_width,
    input  logic [LIMIT_W-1:0] instruction_limit,
    output logic               wr_en,
    output logic [PTR_W-1:0]   wr_addr,
    output entry_t             wr_data,
    output logic               rd_en,
    output logic [PTR_W-1:0]   rd_addr,
    input  entry_t             rd_data,
    output logic               res_valid,
    output result_t            res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_EVAL   = 4'b0100,
        S_CREDIT = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic [LIMIT_W-1:0]       total_reg, total_next;
    logic                     halted_reg, halted_next;
    logic [CNT_W-1:0]         remain_reg, remain_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [BUFFER_DEPTH-1:0]  done_reg, done_next;

    logic                     accept;
    logic [CMP_W-1:0]         slot_ext;
    logic [CMP_W-1:0]         head_ext;
    logic [CMP_W-1:0]         depth_ext;
    logic [CMP_W-1:0]         slot_gap;
    logic                     complete_ok;
    logic [CMP_W-1:0]         rw_ext;
    logic [CMP_W-1:0]         rw_sat;
    logic [CMP_W-1:0]         rw_lim;
    logic [CMP_W-1:0]         width_eff;
    logic [LIMIT_W-1:0]       total_inc;
    logic                     limit_hit;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && (state_reg == S_IDLE);

    // Completion check: the slot must lie inside the occupied window.
    assign slot_ext  = CMP_W'(target_slot);
    assign head_ext  = CMP_W'(head_reg);
    assign depth_ext = CMP_W'(BUFFER_DEPTH);
    assign slot_gap = (slot_ext >= head_ext) ? (slot_ext - head_ext)
                                             : (slot_ext + depth_ext - head_ext);
    assign complete_ok = (slot_ext < depth_ext) && (slot_gap < CMP_W'(occ_reg));

    // Number of entries this retire cycle may pop.
    assign rw_ext = CMP_W'(retire_width);
    assign rw_sat = (rw_ext > CMP_W'(MAX_RETIRE_WIDTH)) ? CMP_W'(MAX_RETIRE_WIDTH) : rw_ext;
    assign rw_lim = (rw_sat > CMP_W'(occ_reg)) ? CMP_W'(occ_reg) : rw_sat;
    assign width_eff = halted_reg ? '0 : rw_lim;

    // Instruction limit check for the entry being retired.
    assign total_inc = total_reg + LIMIT_W'(1);
    assign limit_hit = (instruction_limit != '0) && (total_inc == instruction_limit);

    // Append data goes straight to the tail slot.
    assign wr_addr = tail_reg;
    assign wr_data = '{flush: flush_flag, store: store_flag,
                       address: inst_address, id: inst_id};

    // Next-state logic of the buffer and the retire sequencer.
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        total_next  = total_reg;
        halted_next = halted_reg;
        remain_next = remain_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.kind    = KIND_SLOT;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(op))
                        OP_APPEND:
                        begin
                            res_valid = 1'b1;
                            res.last  = 1'b1;
                            if (occ_reg >= OCC_W'(BUFFER_DEPTH))
                            begin
                                res.kind = KIND_FULL;
                            end
                            else
                            begin
                                wr_en               = 1'b1;
                                done_next[tail_reg] = 1'b0;
                                tail_next           = ptr_inc(tail_reg);
                                occ_next            = occ_reg + OCC_W'(1);
                                res.kind            = KIND_SLOT;
                                res.slot_index      = SLOT_W'(tail_reg);
                            end
                        end
                        OP_COMPLETE:
                        begin
                            if (complete_ok)
                            begin
                                done_next[slot_ext[PTR_W-1:0]] = 1'b1;
                            end
                        end
                        OP_RETIRE:
                        begin
                            count_next = '0;
                            if (width_eff == '0)
                            begin
                                res_valid    = 1'b1;
                                res.kind     = KIND_CREDIT;
                                res.halt     = halted_reg;
                                res.last     = 1'b1;
                            end
                            else
                            begin
                                remain_next = CNT_W'(width_eff);
                                state_next  = S_READ;
                            end
                        end
                        OP_FLUSH:
                        begin
                            head_next        = '0;
                            tail_next        = '0;
                            occ_next         = '0;
                            res_valid        = 1'b1;
                            res.kind         = KIND_CREDIT;
                            res.halt         = halted_reg;
                            res.credit_count = CREDIT_W'(occ_reg);
                            res.last         = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Fetch the head entry.
            S_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_reg;
                state_next = S_EVAL;
            end

            // Retire the head entry, or stop at an entry not yet complete.
            S_EVAL:
            begin
                res_valid = 1'b1;
                if (!done_reg[head_reg])
                begin
                    res.kind         = KIND_CREDIT;
                    res.halt         = halted_reg;
                    res.credit_count = CREDIT_W'(count_reg);
                    res.last         = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    done_next[head_reg] = 1'b0;
                    head_next           = ptr_inc(head_reg);
                    occ_next            = occ_reg - OCC_W'(1);
                    total_next          = total_inc;
                    count_next          = count_reg + CNT_W'(1);
                    remain_next         = remain_reg - CNT_W'(1);
                    res.kind            = KIND_RETIRED;
                    res.retired_id      = rd_data.id;
                    res.store_ack       = rd_data.store;
                    if (limit_hit)
                    begin
                        halted_next = 1'b1;
                        res.halt    = 1'b1;
                        state_next  = S_CREDIT;
                    end
                    else if (rd_data.flush)
                    begin
                        res.flush_out        = 1'b1;
                        res.redirect_address = rd_data.address + REDIRECT_STEP;
                        state_next           = S_CREDIT;
                    end
                    else if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_CREDIT;
                    end
                    else
                    begin
                        // Prefetch the next head entry while this one retires.
                        rd_en   = 1'b1;
                        rd_addr = ptr_inc(head_reg);
                    end
                end
            end

            // Closing credit report of a retire cycle.
            S_CREDIT:
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_CREDIT;
                res.halt         = halted_reg;
                res.credit_count = CREDIT_W'(count_reg);
                res.last         = 1'b1;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            occ_reg    <= '0;
            total_reg  <= '0;
            halted_reg <= 1'b0;
            remain_reg <= '0;
            count_reg  <= '0;
            done_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            total_reg  <= total_next;
            halted_reg <= halted_next;
            remain_reg <= remain_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

endmodule

// ===== design/reorder_buffer_retire_unit.sv =====
// ============================================================================
// Reorder buffer retire unit
// In-order reorder buffer with append, completion, multi-entry retire and
// flush, plus its configuration registers and result register.
// ============================================================================
// An item is taken on a clock edge with start high and busy low; op selects
// append, mark complete, retire cycle or flush. Append, mark complete and
// flush leave busy low, so a new item can follow at once; the single result
// of an append or flush appears on the result ports in the next cycle with
// result_valid high. Mark complete gives no result.
// A retire cycle raises busy and walks the head of the entry memory: it
// fetches the head, then retires entries in order (the next entry is
// prefetched while one retires), then gives the credit report; no entry
// retires when the head is not yet complete. A retire cycle that may pop
// nothing (halted, empty buffer or width zero) leaves busy low and answers
// in the next cycle. The registered entry memory read port sets the pace.
// Each result is shown for one cycle; last marks the final result of an
// item. The receiver cannot stall results. The user must write
// configuration through cfg_we, cfg_index and cfg_data only while the
// block is idle; the block itself does not enforce this.
// Reset empties the buffer, clears the retired total and the halt state and
// loads the default retire width of two and a limit of zero.
// ============================================================================
module reorder_buffer_retire_unit
    import rbr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      op,
    input  logic [ID_W-1:0]      inst_id,
    input  logic [ADDR_W-1:0]    inst_address,
    input  logic                 store_flag,
    input  logic                 flush_flag,
    input  logic [SLOT_W-1:0]    target_slot,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 result_valid,
    output logic [1:0]           kind,
    output logic [SLOT_W-1:0]    slot_index,
    output logic [ID_W-1:0]      retired_id,
    output logic                 store_ack,
    output logic                 flush_out,
    output logic [ADDR_W-1:0]    redirect_address,
    output logic                 halt,
    output logic [CREDIT_W-1:0]  credit_count,
    output logic                 last
);

    logic [RW_W-1:0]    retire_width_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    entry_t             rd_data;
    logic               res_valid;
    result_t            res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retire_width_reg <= RW_W'(2);
            limit_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RETIRE_WIDTH:
                begin
                    retire_width_reg <= cfg_data[RW_W-1:0];
                end
                CFG_INSTRUCTION_LIMIT:
                begin
                    limit_reg <= cfg_data[LIMIT_W-1:0];
                end
                default:
                begin
                    limit_reg <= limit_reg;
                end
            endcase
        end
    end

    // Entry storage.
    rbr_entry_ram u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pointers and retire sequencer.
    rbr_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .op                (op),
        .inst_id           (inst_id),
        .inst_address      (inst_address),
        .store_flag        (store_flag),
        .flush_flag        (flush_flag),
        .target_slot       (target_slot),
        .retire_width      (retire_width_reg),
        .instruction_limit (limit_reg),
        .wr_en             (wr_en),
        .wr_addr           (wr_addr),
        .wr_data           (wr_data),
        .rd_en             (rd_en),
        .rd_addr           (rd_addr),
        .rd_data           (rd_data),
        .res_valid         (res_valid),
        .res               (res)
    );

    // Result register: the strobe is reset, the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            result_reg <= res;
        end
    end

    assign result_valid     = result_valid_reg;
    assign kind             = result_reg.kind;
    assign slot_index       = result_reg.slot_index;
    assign retired_id       = result_reg.retired_id;
    assign store_ack        = result_reg.store_ack;
    assign flush_out        = result_reg.flush_out;
    assign redirect_address = result_reg.redirect_address;
    assign halt             = result_reg.halt;
    assign credit_count     = result_reg.credit_count;
    assign last             = result_reg.last;

`ifndef SYNTHESIS
    // Only a retire cycle makes the block busy.
    a_busy_from_retire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && ($past(op) == OP_RETIRE)))
        else $error("busy rose without an accepted retire item");

    // A retire cycle ends with its final credit report on the ports.
    a_busy_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last && (kind == KIND_CREDIT)))
        else $error("retire cycle ended without a final credit result");

    // A flush is signaled only by a retired entry that did not halt.
    a_flush_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && flush_out) |-> ((kind == KIND_RETIRED) && !halt && !last))
        else $error("flush signaled on a wrong result");

    // Append results are always single and final.
    a_append_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ((kind == KIND_SLOT) || (kind == KIND_FULL))) |-> last)
        else $error("append result not marked last");
`endif

endmodule

// ===== sim/reorder_buffer_retire_unit_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Reorder buffer retire unit checker
// Watches the item, configuration and result ports of the retire unit. It
// keeps its own copy of the buffer state, predicts the results of every
// accepted item and compares each result, field by field, with the oldest
// prediction still waiting.
// ============================================================================
module reorder_buffer_retire_unit_checker
    import rbr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [OP_W-1:0]      op,
    input  logic [ID_W-1:0]      inst_id,
    input  logic [ADDR_W-1:0]    inst_address,
    input  logic                 store_flag,
    input  logic                 flush_flag,
    input  logic [SLOT_W-1:0]    target_slot,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 result_valid,
    input  logic [1:0]           kind,
    input  logic [SLOT_W-1:0]    slot_index,
    input  logic [ID_W-1:0]      retired_id,
    input  logic                 store_ack,
    input  logic                 flush_out,
    input  logic [ADDR_W-1:0]    redirect_address,
    input  logic                 halt,
    input  logic [CREDIT_W-1:0]  credit_count,
    input  logic                 last,
    output int                   error_count,
    output int                   pending_count,
    output int                   item_count,
    output int                   result_count,
    output int                   retire_count,
    output int                   reject_count,
    output logic [PTR_W-1:0]     head_slot,
    output int                   fill_level,
    output logic [31:0]          retired_total,
    output logic                 halted_state
);

    // One buffer entry as the checker tracks it.
    typedef struct {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] address;
        logic              store;
        logic              flush;
        logic              done;
    } slot_rec_t;

    slot_rec_t         slots [BUFFER_DEPTH];
    logic [PTR_W-1:0]  tail_q;
    logic [RW_W-1:0]   width_reg;
    logic [LIMIT_W-1:0] limit_reg;
    result_t           expected_q [$];

    // A result with every field cleared but its kind and last flag.
    function automatic result_t fresh_result(input kind_t k, input logic fin);
        result_t r;
        r = '0;
        r.kind = k;
        r.last = fin;
        return r;
    endfunction

    // Work out the results of one accepted item and advance the buffer state.
    task automatic predict_item();
        result_t          r;
        logic [PTR_W-1:0] slot_gap;
        slot_rec_t        e;
        int               lim;
        int               n;
        logic             stop;
        case (op)
            OP_APPEND:
            begin
                if (fill_level >= BUFFER_DEPTH)
                begin
                    expected_q.push_back(fresh_result(KIND_FULL, 1'b1));
                end
                else
                begin
                    slots[tail_q] = '{inst_id, inst_address, store_flag, flush_flag, 1'b0};
                    r = fresh_result(KIND_SLOT, 1'b1);
                    r.slot_index = tail_q;
                    expected_q.push_back(r);
                    tail_q = tail_q + 1'b1;
                    fill_level = fill_level + 1;
                end
            end
            OP_COMPLETE:
            begin
                // Only slots between head and tail may be marked.
                slot_gap = target_slot - head_slot;
                if (int'(slot_gap) < fill_level)
                begin
                    slots[target_slot].done = 1'b1;
                end
            end
            OP_FLUSH:
            begin
                r = fresh_result(KIND_CREDIT, 1'b1);
                r.halt = halted_state;
                r.credit_count = CREDIT_W'(fill_level);
                expected_q.push_back(r);
                head_slot = '0;
                tail_q = '0;
                fill_level = 0;
            end
            default:
            begin
                // Retire cycle: walk completed head entries in order.
                lim = (width_reg > MAX_RETIRE_WIDTH) ? MAX_RETIRE_WIDTH : int'(width_reg);
                if (lim > fill_level)
                begin
                    lim = fill_level;
                end
                if (halted_state)
                begin
                    lim = 0;
                end
                n = 0;
                stop = 1'b0;
                while (n < lim && !stop)
                begin
                    e = slots[head_slot];
                    if (!e.done)
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        slots[head_slot] = '{e.id, e.address, 1'b0, 1'b0, 1'b0};
                        head_slot = head_slot + 1'b1;
                        fill_level = fill_level - 1;
                        retired_total = retired_total + 1;
                        n = n + 1;
                        r = fresh_result(KIND_RETIRED, 1'b0);
                        r.retired_id = e.id;
                        r.store_ack = e.store;
                        // Reaching the limit wins over a flush on the same entry.
                        if (limit_reg != '0 && retired_total == limit_reg)
                        begin
                            halted_state = 1'b1;
                            r.halt = 1'b1;
                            stop = 1'b1;
                        end
                        else if (e.flush)
                        begin
                            r.flush_out = 1'b1;
                            r.redirect_address = e.address + REDIRECT_STEP;
                            stop = 1'b1;
                        end
                        expected_q.push_back(r);
                    end
                end
                r = fresh_result(KIND_CREDIT, 1'b1);
                r.halt = halted_state;
                r.credit_count = CREDIT_W'(n);
                expected_q.push_back(r);
            end
        endcase
    endtask

    // Report one field that differs from its prediction.
    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            error_count = error_count + 1;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // Compare one observed result with the oldest prediction.
    task automatic compare_result();
        result_t want;
        if (expected_q.size() == 0)
        begin
            error_count = error_count + 1;
            $display("%0t ns: result with nothing expected, expected none, actual kind %0d",
                     $time, kind);
        end
        else
        begin
            want = expected_q.pop_front();
            note_field("kind", want.kind, kind);
            note_field("slot_index", want.slot_index, slot_index);
            note_field("retired_id", want.retired_id, retired_id);
            note_field("store_ack", want.store_ack, store_ack);
            note_field("flush_out", want.flush_out, flush_out);
            note_field("redirect_address", want.redirect_address, redirect_address);
            note_field("halt", want.halt, halt);
            note_field("credit_count", want.credit_count, credit_count);
            note_field("last", want.last, last);
        end
    endtask

    // Results are checked before a new item is predicted: a result never
    // belongs to the item accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            head_slot = '0;
            tail_q = '0;
            fill_level = 0;
            retired_total = '0;
            halted_state = 1'b0;
            width_reg = RW_W'(2);
            limit_reg = '0;
            error_count = 0;
            pending_count = 0;
            item_count = 0;
            result_count = 0;
            retire_count = 0;
            reject_count = 0;
        end
        else
        begin
            if (result_valid)
            begin
                compare_result();
                result_count = result_count + 1;
                if (kind == KIND_RETIRED)
                begin
                    retire_count = retire_count + 1;
                end
                if (kind == KIND_FULL)
                begin
                    reject_count = reject_count + 1;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_RETIRE_WIDTH)
                begin
                    width_reg = cfg_data[RW_W-1:0];
                end
                else
                begin
                    limit_reg = cfg_data[LIMIT_W-1:0];
                end
            end
            if (start && !busy)
            begin
                predict_item();
                item_count = item_count + 1;
            end
            pending_count = expected_q.size();
        end
    end

endmodule

// ===== sim/reorder_buffer_retire_unit_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Reorder buffer retire unit testbench
// Drives appends, completions, retire cycles and flushes into the retire
// unit: a directed opening, then random phases under several retire widths
// and instruction limits, ending with a halt. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ============================================================================
module reorder_buffer_retire_unit_tb;
    import rbr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      inst_id;
    logic [ADDR_W-1:0]    inst_address;
    logic                 store_flag;
    logic                 flush_flag;
    logic [SLOT_W-1:0]    target_slot;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 result_valid;
    logic [1:0]           kind;
    logic [SLOT_W-1:0]    slot_index;
    logic [ID_W-1:0]      retired_id;
    logic                 store_ack;
    logic                 flush_out;
    logic [ADDR_W-1:0]    redirect_address;
    logic                 halt;
    logic [CREDIT_W-1:0]  credit_count;
    logic                 last;

    int                   error_count;
    int                   pending_count;
    int                   item_count;
    int                   result_count;
    int                   retire_count;
    int                   reject_count;
    logic [PTR_W-1:0]     head_slot;
    int                   fill_level;
    logic [31:0]          retired_total;
    logic                 halted_state;

    int                   quiet_cycles;
    logic                 no_gaps;

    reorder_buffer_retire_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .inst_id          (inst_id),
        .inst_address     (inst_address),
        .store_flag       (store_flag),
        .flush_flag       (flush_flag),
        .target_slot      (target_slot),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .kind             (kind),
        .slot_index       (slot_index),
        .retired_id       (retired_id),
        .store_ack        (store_ack),
        .flush_out        (flush_out),
        .redirect_address (redirect_address),
        .halt             (halt),
        .credit_count     (credit_count),
        .last             (last)
    );

    reorder_buffer_retire_unit_checker retire_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .op               (op),
        .inst_id          (inst_id),
        .inst_address     (inst_address),
        .store_flag       (store_flag),
        .flush_flag       (flush_flag),
        .target_slot      (target_slot),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .result_valid     (result_valid),
        .kind             (kind),
        .slot_index       (slot_index),
        .retired_id       (retired_id),
        .store_ack        (store_ack),
        .flush_out        (flush_out),
        .redirect_address (redirect_address),
        .halt             (halt),
        .credit_count     (credit_count),
        .last             (last),
        .error_count      (error_count),
        .pending_count    (pending_count),
        .item_count       (item_count),
        .result_count     (result_count),
        .retire_count     (retire_count),
        .reject_count     (reject_count),
        .head_slot        (head_slot),
        .fill_level       (fill_level),
        .retired_total    (retired_total),
        .halted_state     (halted_state)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // The run fails if neither an item, a result nor a write moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: watchdog expired with %0d results outstanding",
                     $time, pending_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Wait the drawn gap; returns on the falling edge where the item goes out.
    task automatic hold_gap();
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
    endtask

    // Present one item and wait for the edge that takes it.
    task automatic launch(input logic [OP_W-1:0] code, input logic [ID_W-1:0] id,
                          input logic [ADDR_W-1:0] addr, input logic st,
                          input logic fl, input logic [SLOT_W-1:0] slot);
        start        <= 1'b1;
        op           <= code;
        inst_id      <= id;
        inst_address <= addr;
        store_flag   <= st;
        flush_flag   <= fl;
        target_slot  <= slot;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    task automatic issue(input logic [OP_W-1:0] code, input logic [ID_W-1:0] id,
                         input logic [ADDR_W-1:0] addr, input logic st,
                         input logic fl, input logic [SLOT_W-1:0] slot);
        hold_gap();
        launch(code, id, addr, st, fl, slot);
    endtask

    // One random item; the mix gives the append, complete and retire shares
    // in percent, the rest are flushes. Completions mostly hit occupied slots.
    task automatic issue_random(input int append_pct, input int complete_pct,
                                input int retire_pct);
        int                r;
        logic [OP_W-1:0]   code;
        logic [ADDR_W-1:0] addr;
        logic [SLOT_W-1:0] slot;
        hold_gap();
        r = $urandom_range(0, 99);
        addr = $urandom;
        if ($urandom_range(0, 7) == 0)
        begin
            addr = 32'hFFFF_FFFC | $urandom_range(0, 3);
        end
        slot = SLOT_W'($urandom_range(0, 31));
        if (r < append_pct)
        begin
            code = OP_APPEND;
        end
        else if (r < append_pct + complete_pct)
        begin
            code = OP_COMPLETE;
            if (fill_level > 0 && $urandom_range(0, 6) != 0)
            begin
                slot = SLOT_W'(int'(head_slot) +
                       ($urandom_range(0, 1) ? 0 : int'($urandom_range(0, fill_level - 1))));
            end
        end
        else if (r < append_pct + complete_pct + retire_pct)
        begin
            code = OP_RETIRE;
        end
        else
        begin
            code = OP_FLUSH;
        end
        launch(code, $urandom, addr, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
               slot);
    endtask

    task automatic run_phase(input int count, input int append_pct,
                             input int complete_pct, input int retire_pct);
        repeat (count)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                no_gaps = !no_gaps;
            end
            issue_random(append_pct, complete_pct, retire_pct);
        end
    endtask

    // Register writes happen only once the block has drained and settled.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        // The unused upper bits of a width write carry noise.
        if (idx == CFG_RETIRE_WIDTH)
        begin
            cfg_data <= {28'($urandom_range(0, 32'h0FFF_FFFF)), value[RW_W-1:0]};
        end
        else
        begin
            cfg_data <= value;
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] limit_val;

        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_APPEND;
        inst_id      = '0;
        inst_address = '0;
        store_flag   = 1'b0;
        flush_flag   = 1'b0;
        target_slot  = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_RETIRE_WIDTH;
        cfg_data     = '0;
        no_gaps      = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset width of two.
        issue(OP_RETIRE, 0, 0, 0, 0, 0);
        issue(OP_APPEND, 32'h0000_0000, 32'h0000_0000, 0, 0, 0);
        issue(OP_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 1, 1, 0);
        issue(OP_APPEND, 32'hA5A5_5A5A, 32'h1234_5678, 1, 0, 0);
        // Head not yet complete, and completion of an empty slot.
        issue(OP_RETIRE, 0, 0, 0, 0, 0);
        issue(OP_COMPLETE, 0, 0, 0, 0, 31);
        issue(OP_COMPLETE, 0, 0, 0, 0, 1);
        issue(OP_RETIRE, 0, 0, 0, 0, 0);
        // Retire stops at the flushing entry, whose redirect wraps to zero.
        issue(OP_COMPLETE, 0, 0, 0, 0, 0);
        issue(OP_RETIRE, 0, 0, 0, 0, 0);
        issue(OP_COMPLETE, 0, 0, 0, 0, 2);
        issue(OP_RETIRE, 0, 0, 0, 0, 0);
        // A flush discards completed and pending entries alike.
        issue(OP_APPEND, 32'h0000_0001, 32'h0000_0100, 0, 0, 0);
        issue(OP_APPEND, 32'h0000_0002, 32'h0000_0104, 0, 0, 0);
        issue(OP_COMPLETE, 0, 0, 0, 0, 3);
        issue(OP_FLUSH, 0, 0, 0, 0, 0);
        issue(OP_FLUSH, 0, 0, 0, 0, 0);
        issue(OP_COMPLETE, 0, 0, 0, 0, 0);

        // A width of zero retires nothing.
        write_reg(CFG_RETIRE_WIDTH, 0);
        issue(OP_APPEND, 32'h0000_0010, 32'h0000_0200, 0, 0, 0);
        issue(OP_COMPLETE, 0, 0, 0, 0, 0);
        issue(OP_RETIRE, 0, 0, 0, 0, 0);

        // Random phases across widths and limits that are never reached.
        write_reg(CFG_RETIRE_WIDTH, 15);
        write_reg(CFG_INSTRUCTION_LIMIT, 32'hFFFF_FFFF);
        run_phase(70, 35, 35, 25);
        write_reg(CFG_RETIRE_WIDTH, 1);
        write_reg(CFG_INSTRUCTION_LIMIT, 0);
        run_phase(60, 65, 20, 13);
        write_reg(CFG_RETIRE_WIDTH, 8);
        write_reg(CFG_INSTRUCTION_LIMIT, 32'h8000_0000 | $urandom);
        run_phase(60, 35, 35, 25);
        write_reg(CFG_RETIRE_WIDTH, $urandom_range(0, 15));
        write_reg(CFG_INSTRUCTION_LIMIT, 0);
        run_phase(60, 35, 35, 25);
        write_reg(CFG_RETIRE_WIDTH, 3);
        run_phase(40, 65, 20, 13);

        // Halt on a flushing entry: the limit wins and no flush is signalled.
        write_reg(CFG_RETIRE_WIDTH, 8);
        issue(OP_FLUSH, 0, 0, 0, 0, 0);
        @(negedge clk);
        start <= 1'b0;
        limit_val = retired_total + 3;
        write_reg(CFG_INSTRUCTION_LIMIT, limit_val);
        issue(OP_APPEND, 32'h0000_0101, 32'h0000_1000, 0, 0, 0);
        issue(OP_APPEND, 32'h0000_0102, 32'h0000_1004, 1, 0, 0);
        issue(OP_APPEND, 32'h0000_0103, 32'h0000_1008, 1, 1, 0);
        issue(OP_APPEND, 32'h0000_0104, 32'h0000_100C, 0, 0, 0);
        issue(OP_COMPLETE, 0, 0, 0, 0, 0);
        issue(OP_COMPLETE, 0, 0, 0, 0, 1);
        issue(OP_COMPLETE, 0, 0, 0, 0, 2);
        issue(OP_COMPLETE, 0, 0, 0, 0, 3);
        issue(OP_RETIRE, 0, 0, 0, 0, 0);

        // Once halted, retires report nothing while the rest keeps working.
        run_phase(40, 45, 25, 25);

        // Drain, then let any late result show up.
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (12) @(negedge clk);

        $display("Run covered %0d items and %0d results: %0d entries retired, %0d full rejects.",
                 item_count, result_count, retire_count, reject_count);
        $display("Retire widths 0 to 15 and limits 0 to max were used; halted at end: %0d.",
                 halted_state);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches found", error_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== reorder_buffer_retire_unit.f =====
design/rbr_pkg.sv
design/rbr_entry_ram.sv
design/rbr_ctrl.sv
design/reorder_buffer_retire_unit.sv
sim/reorder_buffer_retire_unit_checker.sv
sim/reorder_buffer_retire_unit_tb.sv
